FILE: src/ifd_pkg.sv
// shared types and constants for the interleaved frame deframer
package ifd_pkg;

	localparam logic [7:0] MARKER_BYTE = 8'h24;

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_CHAN    = 3'd1;
	localparam logic [2:0] PH_LEN_HI  = 3'd2;
	localparam logic [2:0] PH_LEN_LO  = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	localparam logic [1:0] EV_DATA     = 2'd0;
	localparam logic [1:0] EV_FRAMING  = 2'd1;
	localparam logic [1:0] EV_OVERSIZE = 2'd2;

	localparam logic [1:0] REG_DATA_CHANNEL    = 2'd0;
	localparam logic [1:0] REG_CONTROL_CHANNEL = 2'd1;
	localparam logic [1:0] REG_MAX_PAYLOAD     = 2'd2;

	localparam logic [7:0]  RST_DATA_CHANNEL    = 8'd0;
	localparam logic [7:0]  RST_CONTROL_CHANNEL = 8'd1;
	localparam logic [15:0] RST_MAX_PAYLOAD     = 16'd4092;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [1:0]  event_res;
		logic [7:0]  out_byte;
		logic        is_last;
		logic [15:0] frame_length;
	} ifd_res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ifd_q_stat_t;

endpackage

FILE: src/ifd_ifs.sv
// stream, result and configuration channel interfaces
interface ifd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface ifd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic [7:0]  out_byte;
	logic        is_last;
	logic [15:0] frame_length;
	modport source (output valid, output event_res, output out_byte, output is_last,
		output frame_length, input ready);
	modport sink (input valid, input event_res, input out_byte, input is_last,
		input frame_length, output ready);
endinterface

interface ifd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: src/ifd_front.sv
// front end: frame header parser, config registers and result classification
module ifd_front
	import ifd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ifd_byte_if.sink    stream,
	ifd_cfg_if.sink     cfg,
	input  ifd_q_stat_t stat,
	output logic        push,
	output ifd_res_t    push_res
);

	logic [7:0]  data_channel_q;
	logic [7:0]  control_channel_q;
	logic [15:0] max_payload_q;

	logic [2:0]  phase_q;
	logic [7:0]  frame_channel_q;
	logic [15:0] length_word_q;
	logic [15:0] bytes_left_q;

	logic [2:0]  phase_d;
	logic [7:0]  frame_channel_d;
	logic [15:0] length_word_d;
	logic [15:0] bytes_left_d;
	logic        emit;
	logic        accept;
	logic [15:0] len_full;
	logic [15:0] left_dec;

	assign stream.ready = !stat.full;
	assign cfg.ready    = 1'b1;
	assign accept       = stream.valid && stream.ready;
	assign len_full     = {length_word_q[15:8], stream.in_byte};
	assign left_dec     = bytes_left_q - 16'd1;

	always_comb begin
		phase_d         = phase_q;
		frame_channel_d = frame_channel_q;
		length_word_d   = length_word_q;
		bytes_left_d    = bytes_left_q;
		emit            = 1'b0;
		push_res        = '0;
		unique case (phase_q)
			PH_CHAN: begin
				frame_channel_d = stream.in_byte;
				phase_d         = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				length_word_d = {stream.in_byte, 8'h00};
				phase_d       = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				length_word_d = len_full;
				if (len_full > max_payload_q) begin
					phase_d                = PH_HUNT;
					bytes_left_d           = '0;
					emit                   = 1'b1;
					push_res.event_res     = EV_OVERSIZE;
					push_res.frame_length  = len_full;
				end else if (len_full == 16'd0) begin
					phase_d      = PH_HUNT;
					bytes_left_d = '0;
				end else begin
					bytes_left_d = len_full;
					phase_d      = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				bytes_left_d = left_dec;
				if (left_dec == 16'd0) begin
					phase_d = PH_HUNT;
				end
				// data channel wins when it matches the control channel too
				if (frame_channel_q == data_channel_q) begin
					emit                  = 1'b1;
					push_res.event_res    = EV_DATA;
					push_res.out_byte     = stream.in_byte;
					push_res.is_last      = (left_dec == 16'd0);
					push_res.frame_length = length_word_q;
				end
			end
			default: begin
				// hunting, and any unused phase code
				if (stream.in_byte == MARKER_BYTE) begin
					phase_d = PH_CHAN;
				end else begin
					phase_d            = PH_HUNT;
					emit               = 1'b1;
					push_res.event_res = EV_FRAMING;
					push_res.out_byte  = stream.in_byte;
				end
			end
		endcase
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			frame_channel_q <= '0;
			length_word_q   <= '0;
			bytes_left_q    <= '0;
		end else if (accept) begin
			phase_q         <= phase_d;
			frame_channel_q <= frame_channel_d;
			length_word_q   <= length_word_d;
			bytes_left_q    <= bytes_left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_channel_q    <= RST_DATA_CHANNEL;
			control_channel_q <= RST_CONTROL_CHANNEL;
			max_payload_q     <= RST_MAX_PAYLOAD;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_DATA_CHANNEL:    data_channel_q    <= cfg.data[7:0];
				REG_CONTROL_CHANNEL: control_channel_q <= cfg.data[7:0];
				REG_MAX_PAYLOAD:     max_payload_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// control channel payload is dropped like any other non-data channel
	logic unused_ctrl;
	assign unused_ctrl = ^control_channel_q;

endmodule

FILE: src/ifd_fifo.sv
// short result queue between front and back
module ifd_fifo
	import ifd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  ifd_res_t    push_res,
	input  logic        pop,
	output ifd_res_t    head,
	output ifd_q_stat_t stat
);

	ifd_res_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		logic [QPTR_W-1:0] r;
		r = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
		return r;
	endfunction

	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/ifd_back.sv
// back end: output register fed from the result queue
module ifd_back
	import ifd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  ifd_q_stat_t  stat,
	input  ifd_res_t     head,
	output logic         pop,
	ifd_res_if.source    result
);

	logic     out_valid_q;
	ifd_res_t out_res_q;

	assign pop = !stat.empty && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_res_q <= head;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.event_res    = out_res_q.event_res;
	assign result.out_byte     = out_res_q.out_byte;
	assign result.is_last      = out_res_q.is_last;
	assign result.frame_length = out_res_q.frame_length;

endmodule

FILE: src/interleaved_frame_deframer_core.sv
// top level of the interleaved frame deframer
// a result is registered in the result queue and then in the output register
// throughput: one byte per cycle unless the queue is full, set by the header parser
// a four-entry result queue lets the stream keep flowing while the output stalls
// reset: parser hunts for the marker, registers take their defaults, queue is empty
module interleaved_frame_deframer_core
	import ifd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	ifd_byte_if.sink  stream,
	ifd_res_if.source result,
	ifd_cfg_if.sink   cfg
);

	ifd_q_stat_t stat;
	ifd_res_t    push_res;
	ifd_res_t    head;
	logic        push;
	logic        pop;

	ifd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.cfg      (cfg),
		.stat     (stat),
		.push     (push),
		.push_res (push_res)
	);

	ifd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_res (push_res),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	ifd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("result pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("result popped from an empty queue");

	a_framing_fields: assert property (@(posedge clk) disable iff (!arst_n)
		push && (push_res.event_res == EV_FRAMING) |->
			(push_res.frame_length == 16'd0) && !push_res.is_last)
		else $error("framing error result carries frame fields");

	a_pop_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> result.valid)
		else $error("queue pop did not fill the output register");

endmodule
